/* rtl/hkct_pkg.sv */
`timescale 1ns / 1ps

package hkct_pkg;

	localparam int HUE_W   = 8;
	localparam int SAT_W   = 8;
	localparam int COORD_W = 10;
	localparam int SUM_W   = 30;
	localparam int CNT_W   = 21;
	localparam int ALPHA_W = 9;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int ALPHA_ONE = 256;
	localparam int BLEND_RND = 128;
	localparam int BLEND_SH  = 8;
	localparam int BLEND_W   = $clog2(ALPHA_ONE * ((1 << COORD_W) - 1) + BLEND_RND + 1);
	localparam int STEP_W    = $clog2(SUM_W);

	localparam int Q_DEPTH = 4;

	localparam int APB_DW = 32;
	localparam int APB_AW = 4;

	localparam logic [HUE_W-1:0]   HUE_LOWER_RST = HUE_W'(180);
	localparam logic [HUE_W-1:0]   HUE_UPPER_RST = HUE_W'(170);
	localparam logic [SAT_W-1:0]   SAT_THR_RST   = SAT_W'(120);
	localparam logic [ALPHA_W-1:0] ALPHA_RST     = '0;

	// register index, paddr[3:2]
	localparam logic [1:0] REG_HUE_LOWER = 2'd0;
	localparam logic [1:0] REG_HUE_UPPER = 2'd1;
	localparam logic [1:0] REG_SAT_THR   = 2'd2;
	localparam logic [1:0] REG_ALPHA     = 2'd3;

	typedef struct packed {
		logic [HUE_W-1:0]   hue_lower;
		logic [HUE_W-1:0]   hue_upper;
		logic [SAT_W-1:0]   sat_thr;
		logic [ALPHA_W-1:0] alpha;
	} hkct_cfg_t;

	typedef struct packed {
		logic             hit;
		logic             last;
		logic [SUM_W-1:0] sum_col;
		logic [SUM_W-1:0] sum_row;
		logic [CNT_W-1:0] hit_count;
	} hkct_item_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_MUL_C,
		BK_MUL_M,
		BK_WRITE
	} bk_state_t;

endpackage

/* rtl/hkct_front.sv */
`timescale 1ns / 1ps

module hkct_front
	import hkct_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  hkct_cfg_t          cfg,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [HUE_W-1:0]   hue,
	input  logic [SAT_W-1:0]   saturation,
	input  logic [COORD_W-1:0] pos_x,
	input  logic [COORD_W-1:0] pos_y,
	input  logic               frame_last,
	input  logic               q_full,
	output logic               q_push,
	output hkct_item_t         q_item
);

	logic [SUM_W-1:0] sum_col_q, sum_row_q;
	logic [CNT_W-1:0] hit_count_q;

	logic               accept;
	logic               hit;
	logic [COORD_W-1:0] px, py;
	logic [SUM_W:0]     col_ext, row_ext;
	logic [SUM_W-1:0]   col_new, row_new;
	logic [CNT_W-1:0]   cnt_new;

	assign accept   = in_valid && !q_full;
	assign in_stall = q_full;
	assign q_push   = accept;

	always_comb begin
		px = pos_x;
		py = pos_y;
		if (32'(pos_x) >= 32'(MAX_WIDTH)) begin
			px = COORD_W'(MAX_WIDTH - 1);
		end
		if (32'(pos_y) >= 32'(MAX_HEIGHT)) begin
			py = COORD_W'(MAX_HEIGHT - 1);
		end
	end

	// window wraps when lower >= upper
	always_comb begin
		hit = 1'b0;
		if (saturation > cfg.sat_thr) begin
			if (cfg.hue_lower < cfg.hue_upper) begin
				hit = (hue >= cfg.hue_lower) && (hue <= cfg.hue_upper);
			end else begin
				hit = (hue >= cfg.hue_lower) || (hue <= cfg.hue_upper);
			end
		end
	end

	// saturating accumulation
	always_comb begin
		col_ext = {1'b0, sum_col_q} + (SUM_W+1)'(px);
		row_ext = {1'b0, sum_row_q} + (SUM_W+1)'(py);
		col_new = col_ext[SUM_W] ? '1 : col_ext[SUM_W-1:0];
		row_new = row_ext[SUM_W] ? '1 : row_ext[SUM_W-1:0];
		cnt_new = (&hit_count_q) ? hit_count_q : hit_count_q + CNT_W'(1);
	end

	always_comb begin
		q_item.hit       = hit;
		q_item.last      = frame_last;
		q_item.sum_col   = hit ? col_new : sum_col_q;
		q_item.sum_row   = hit ? row_new : sum_row_q;
		q_item.hit_count = hit ? cnt_new : hit_count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_col_q   <= '0;
			sum_row_q   <= '0;
			hit_count_q <= '0;
		end else if (accept) begin
			if (frame_last) begin
				sum_col_q   <= '0;
				sum_row_q   <= '0;
				hit_count_q <= '0;
			end else if (hit) begin
				sum_col_q   <= col_new;
				sum_row_q   <= row_new;
				hit_count_q <= cnt_new;
			end
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && frame_last) |=> (hit_count_q == '0 && sum_col_q == '0 && sum_row_q == '0))
		else $error("accumulators not cleared after frame end");

	a_sums_need_hits: assert property (@(posedge clk) disable iff (!arst_n)
		(hit_count_q == '0) |-> (sum_col_q == '0 && sum_row_q == '0))
		else $error("sums held without keyed pixels");

endmodule

/* rtl/hkct_queue.sv */
`timescale 1ns / 1ps

module hkct_queue
	import hkct_pkg::*;
#(
	parameter int DEPTH = Q_DEPTH
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  hkct_item_t wr_item,
	input  logic       push,
	output logic       full,
	input  logic       pop,
	output logic       empty,
	output hkct_item_t rd_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LVL_W = $clog2(DEPTH + 1);

	hkct_item_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [LVL_W-1:0] level_q;

	assign full    = (level_q == LVL_W'(DEPTH));
	assign empty   = (level_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				level_q <= level_q + LVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - LVL_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("word pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("word popped from empty queue");

endmodule

/* rtl/hkct_div.sv */
`timescale 1ns / 1ps

module hkct_div
	import hkct_pkg::*;
(
	input  logic             clk,
	input  logic             load,
	input  logic             step,
	input  logic [SUM_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic [SUM_W-1:0] quotient
);

	// restoring division, one quotient bit per step, msb first
	logic [SUM_W-1:0] dvd_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] dsr_q;
	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;
	logic             qbit;

	assign trial    = {rem_q, dvd_q[SUM_W-1]};
	assign diff     = trial - {1'b0, dsr_q};
	assign qbit     = (trial >= {1'b0, dsr_q});
	assign quotient = dvd_q;

	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (step) begin
			dvd_q <= {dvd_q[SUM_W-2:0], qbit};
			rem_q <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

endmodule

/* rtl/hkct_back.sv */
`timescale 1ns / 1ps

module hkct_back
	import hkct_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  hkct_cfg_t          cfg,
	input  hkct_item_t         q_item,
	input  logic               q_empty,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               key_hit,
	output logic               frame_done,
	output logic [COORD_W-1:0] center_x,
	output logic [COORD_W-1:0] center_y,
	output logic               center_updated
);

	bk_state_t state_q, state_d;

	logic [STEP_W-1:0]  step_q;
	logic [COORD_W-1:0] track_x_q, track_y_q;
	logic [BLEND_W-1:0] prod_x_q, prod_y_q;
	logic [BLEND_W-1:0] blend_x_q, blend_y_q;
	logic               hold_hit_q;

	logic               out_valid_q;
	logic               key_hit_q, frame_done_q, updated_q;
	logic [COORD_W-1:0] center_x_q, center_y_q;

	logic               out_free;
	logic               long_item;
	logic               out_load_pix;
	logic               out_load_ctr;
	logic               div_load;
	logic               div_step;
	logic [SUM_W-1:0]   quo_x, quo_y;
	logic [COORD_W-1:0] mean_x, mean_y;
	logic [ALPHA_W-1:0] alpha_c, alpha_inv;

	assign out_free  = !out_valid_q || !out_stall;
	assign long_item = q_item.last && (q_item.hit_count != '0);

	assign alpha_c   = (cfg.alpha > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : cfg.alpha;
	assign alpha_inv = ALPHA_W'(ALPHA_ONE) - alpha_c;

	// mean clamps to the coordinate range
	assign mean_x = (|quo_x[SUM_W-1:COORD_W]) ? '1 : quo_x[COORD_W-1:0];
	assign mean_y = (|quo_y[SUM_W-1:COORD_W]) ? '1 : quo_y[COORD_W-1:0];

	hkct_div u_div_x (
		.clk      (clk),
		.load     (div_load),
		.step     (div_step),
		.dividend (q_item.sum_col),
		.divisor  (q_item.hit_count),
		.quotient (quo_x)
	);

	hkct_div u_div_y (
		.clk      (clk),
		.load     (div_load),
		.step     (div_step),
		.dividend (q_item.sum_row),
		.divisor  (q_item.hit_count),
		.quotient (quo_y)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty && out_free && long_item) begin
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (step_q == STEP_W'(SUM_W - 1)) begin
					state_d = BK_MUL_C;
				end
			end
			BK_MUL_C: state_d = BK_MUL_M;
			BK_MUL_M: state_d = BK_WRITE;
			BK_WRITE: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop        = 1'b0;
		out_load_pix = 1'b0;
		out_load_ctr = 1'b0;
		div_load     = 1'b0;
		div_step     = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty && out_free) begin
					q_pop        = 1'b1;
					div_load     = long_item;
					out_load_pix = !long_item;
				end
			end
			BK_DIV:   div_step = 1'b1;
			BK_MUL_C: ;
			BK_MUL_M: ;
			BK_WRITE: out_load_ctr = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			step_q      <= '0;
			track_x_q   <= '0;
			track_y_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (div_load) begin
				step_q <= '0;
			end else if (div_step) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (out_load_ctr) begin
				track_x_q <= blend_x_q[BLEND_SH +: COORD_W];
				track_y_q <= blend_y_q[BLEND_SH +: COORD_W];
			end
			if (out_load_pix || out_load_ctr) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_load) begin
			hold_hit_q <= q_item.hit;
		end
		if (state_q == BK_MUL_C) begin
			prod_x_q <= BLEND_W'(alpha_inv) * BLEND_W'(track_x_q);
			prod_y_q <= BLEND_W'(alpha_inv) * BLEND_W'(track_y_q);
		end
		if (state_q == BK_MUL_M) begin
			blend_x_q <= prod_x_q + BLEND_W'(alpha_c) * BLEND_W'(mean_x) + BLEND_W'(BLEND_RND);
			blend_y_q <= prod_y_q + BLEND_W'(alpha_c) * BLEND_W'(mean_y) + BLEND_W'(BLEND_RND);
		end
		if (out_load_pix) begin
			key_hit_q    <= q_item.hit;
			frame_done_q <= q_item.last;
			center_x_q   <= track_x_q;
			center_y_q   <= track_y_q;
			updated_q    <= 1'b0;
		end else if (out_load_ctr) begin
			key_hit_q    <= hold_hit_q;
			frame_done_q <= 1'b1;
			center_x_q   <= blend_x_q[BLEND_SH +: COORD_W];
			center_y_q   <= blend_y_q[BLEND_SH +: COORD_W];
			updated_q    <= 1'b1;
		end
	end

	assign out_valid      = out_valid_q;
	assign key_hit        = key_hit_q;
	assign frame_done     = frame_done_q;
	assign center_x       = center_x_q;
	assign center_y       = center_y_q;
	assign center_updated = updated_q;

	a_track_moves_on_update: assert property (@(posedge clk) disable iff (!arst_n)
		!($stable(track_x_q) && $stable(track_y_q)) |-> $past(out_load_ctr))
		else $error("tracked centre changed outside a frame update");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == BK_IDLE && out_free))
		else $error("queue popped while back end busy");

endmodule

/* rtl/hsv_key_centroid_tracker_top.sv */
`timescale 1ns / 1ps

// hsv colour key with smoothed centroid tracker
// input channel: in_valid / in_stall with hue, saturation, pos_x, pos_y and
// frame_last; one pixel word is taken on each edge with in_valid high and
// in_stall low. output channel: out_valid / out_stall, one result word per
// pixel, in pixel order, held steady while out_stall is high.
// an ordinary pixel word passes through the queue and the output register,
// and input pixels stream at one per cycle while in_stall is low. a frame-last
// pixel whose frame keyed at least one pixel runs a bit-serial mean division
// (both axes in parallel) and then the multiply states BK_MUL_C and BK_MUL_M
// for the blend before its word leaves.
// a four word queue sits between the classifier and the result side, so the
// input keeps flowing while that division runs until the queue fills; then
// in_stall rises. a stalled receiver fills the output register and then the
// queue before in_stall rises. reset clears sums, count and tracked centre
// and loads the register defaults; configuration must be written through the
// apb port only while the block is idle, and the block does not enforce it.
module hsv_key_centroid_tracker_top
	import hkct_pkg::*;
#(
	parameter int QUEUE_DEPTH = Q_DEPTH
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [HUE_W-1:0]   hue,
	input  logic [SAT_W-1:0]   saturation,
	input  logic [COORD_W-1:0] pos_x,
	input  logic [COORD_W-1:0] pos_y,
	input  logic               frame_last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               key_hit,
	output logic               frame_done,
	output logic [COORD_W-1:0] center_x,
	output logic [COORD_W-1:0] center_y,
	output logic               center_updated
);

	hkct_cfg_t  cfg_q;
	hkct_item_t push_item, head_item;
	logic       q_push, q_full;
	logic       q_pop, q_empty;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hue_lower <= HUE_LOWER_RST;
			cfg_q.hue_upper <= HUE_UPPER_RST;
			cfg_q.sat_thr   <= SAT_THR_RST;
			cfg_q.alpha     <= ALPHA_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_HUE_LOWER: cfg_q.hue_lower <= pwdata[HUE_W-1:0];
				REG_HUE_UPPER: cfg_q.hue_upper <= pwdata[HUE_W-1:0];
				REG_SAT_THR:   cfg_q.sat_thr   <= pwdata[SAT_W-1:0];
				REG_ALPHA:     cfg_q.alpha     <= pwdata[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_HUE_LOWER: prdata = APB_DW'(cfg_q.hue_lower);
			REG_HUE_UPPER: prdata = APB_DW'(cfg_q.hue_upper);
			REG_SAT_THR:   prdata = APB_DW'(cfg_q.sat_thr);
			REG_ALPHA:     prdata = APB_DW'(cfg_q.alpha);
			default:       prdata = '0;
		endcase
	end

	hkct_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.hue        (hue),
		.saturation (saturation),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.frame_last (frame_last),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (push_item)
	);

	hkct_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_item (push_item),
		.push    (q_push),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.rd_item (head_item)
	);

	hkct_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.q_item         (head_item),
		.q_empty        (q_empty),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.key_hit        (key_hit),
		.frame_done     (frame_done),
		.center_x       (center_x),
		.center_y       (center_y),
		.center_updated (center_updated)
	);

endmodule

/* tb/sv/hsv_key_centroid_checker.sv */
`timescale 1ns / 1ps

module hsv_key_centroid_checker
	import hkct_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	input  logic               pready,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [HUE_W-1:0]   hue,
	input  logic [SAT_W-1:0]   saturation,
	input  logic [COORD_W-1:0] pos_x,
	input  logic [COORD_W-1:0] pos_y,
	input  logic               frame_last,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               key_hit,
	input  logic               frame_done,
	input  logic [COORD_W-1:0] center_x,
	input  logic [COORD_W-1:0] center_y,
	input  logic               center_updated,
	output int                 mismatches,
	output int                 outstanding
);

	typedef struct packed {
		logic               key_hit;
		logic               frame_done;
		logic [COORD_W-1:0] center_x;
		logic [COORD_W-1:0] center_y;
		logic               center_updated;
	} result_word_t;

	result_word_t expected_words[$];

	logic [HUE_W-1:0]   win_lo;
	logic [HUE_W-1:0]   win_hi;
	logic [SAT_W-1:0]   sat_floor;
	logic [ALPHA_W-1:0] alpha_w;

	logic [SUM_W-1:0]   col_sum;
	logic [SUM_W-1:0]   row_sum;
	logic [CNT_W-1:0]   keyed_cnt;
	logic [COORD_W-1:0] centre_x;
	logic [COORD_W-1:0] centre_y;

	int err_count;

	task automatic track_pixel(
		input  logic [HUE_W-1:0]   h,
		input  logic [SAT_W-1:0]   s,
		input  logic [COORD_W-1:0] px,
		input  logic [COORD_W-1:0] py,
		input  logic               last,
		output result_word_t       w
	);
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] mean_x;
		logic [COORD_W-1:0] mean_y;
		logic [SUM_W:0]     wide;
		logic [SUM_W-1:0]   q_x;
		logic [SUM_W-1:0]   q_y;
		int unsigned        a;
		logic               hit;

		col = (int'(px) > MAX_WIDTH - 1) ? COORD_W'(MAX_WIDTH - 1) : px;
		row = (int'(py) > MAX_HEIGHT - 1) ? COORD_W'(MAX_HEIGHT - 1) : py;

		hit = 1'b0;
		if (s > sat_floor) begin
			if (win_lo < win_hi)
				hit = (h >= win_lo) && (h <= win_hi);
			else
				hit = (h >= win_lo) || (h <= win_hi);
		end

		w = '0;
		w.key_hit = hit;
		w.frame_done = last;

		// sums saturate at all ones, so a carry out means clamp
		if (hit) begin
			wide = {1'b0, col_sum} + (SUM_W+1)'(col);
			col_sum = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
			wide = {1'b0, row_sum} + (SUM_W+1)'(row);
			row_sum = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
			if (keyed_cnt != '1)
				keyed_cnt = keyed_cnt + CNT_W'(1);
		end

		if (last) begin
			if (keyed_cnt != '0) begin
				a = (alpha_w > ALPHA_ONE) ? ALPHA_ONE : alpha_w;
				q_x = col_sum / SUM_W'(keyed_cnt);
				q_y = row_sum / SUM_W'(keyed_cnt);
				mean_x = (q_x > {COORD_W{1'b1}}) ? '1 : q_x[COORD_W-1:0];
				mean_y = (q_y > {COORD_W{1'b1}}) ? '1 : q_y[COORD_W-1:0];
				centre_x = COORD_W'(((ALPHA_ONE - a) * centre_x + a * mean_x + BLEND_RND)
					>> BLEND_SH);
				centre_y = COORD_W'(((ALPHA_ONE - a) * centre_y + a * mean_y + BLEND_RND)
					>> BLEND_SH);
				w.center_updated = 1'b1;
			end
			col_sum = '0;
			row_sum = '0;
			keyed_cnt = '0;
		end

		w.center_x = centre_x;
		w.center_y = centre_y;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_word_t got;
		result_word_t want;
		if (!arst_n) begin
			expected_words.delete();
			win_lo = HUE_LOWER_RST;
			win_hi = HUE_UPPER_RST;
			sat_floor = SAT_THR_RST;
			alpha_w = ALPHA_RST;
			col_sum = '0;
			row_sum = '0;
			keyed_cnt = '0;
			centre_x = '0;
			centre_y = '0;
			err_count = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {key_hit, frame_done, center_x, center_y, center_updated};
				if (expected_words.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("%0t: unexpected word h%0d d%0d x%0d y%0d u%0d",
							$time, got.key_hit, got.frame_done, got.center_x,
							got.center_y, got.center_updated);
				end else begin
					want = expected_words.pop_front();
					if (got.key_hit !== want.key_hit || got.frame_done !== want.frame_done
						|| got.center_x !== want.center_x || got.center_y !== want.center_y
						|| got.center_updated !== want.center_updated) begin
						err_count++;
						if (err_count <= 10)
							$display("%0t: exp h%0d d%0d x%0d y%0d u%0d got h%0d d%0d x%0d y%0d u%0d",
								$time, want.key_hit, want.frame_done, want.center_x,
								want.center_y, want.center_updated, got.key_hit,
								got.frame_done, got.center_x, got.center_y,
								got.center_updated);
					end
				end
			end

			if (in_valid && !in_stall) begin
				track_pixel(hue, saturation, pos_x, pos_y, frame_last, want);
				expected_words.push_back(want);
			end

			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_AW-1:2])
					REG_HUE_LOWER: win_lo = pwdata[HUE_W-1:0];
					REG_HUE_UPPER: win_hi = pwdata[HUE_W-1:0];
					REG_SAT_THR:   sat_floor = pwdata[SAT_W-1:0];
					REG_ALPHA:     alpha_w = pwdata[ALPHA_W-1:0];
					default: ;
				endcase
			end

			outstanding <= expected_words.size();
			mismatches <= err_count;
		end
	end

endmodule

/* tb/sv/hsv_key_centroid_tracker_top_tb.sv */
`timescale 1ns / 1ps

module hsv_key_centroid_tracker_top_tb;
	import hkct_pkg::*;

	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 190;
	localparam int HOLD_CYCLES = 160;
	localparam int SETTLE      = 48;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [APB_AW-1:0]  paddr = '0;
	logic [APB_DW-1:0]  pwdata = '0;
	logic [APB_DW-1:0]  prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [HUE_W-1:0]   hue = '0;
	logic [SAT_W-1:0]   saturation = '0;
	logic [COORD_W-1:0] pos_x = '0;
	logic [COORD_W-1:0] pos_y = '0;
	logic               frame_last = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               key_hit;
	logic               frame_done;
	logic [COORD_W-1:0] center_x;
	logic [COORD_W-1:0] center_y;
	logic               center_updated;

	int mismatches;
	int outstanding;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;

	int pixels_sent = 0;
	int frames_sent = 0;
	int settings_used = 0;

	logic [HUE_W-1:0]   cur_lo = HUE_LOWER_RST;
	logic [HUE_W-1:0]   cur_hi = HUE_UPPER_RST;
	logic [SAT_W-1:0]   cur_thr = SAT_THR_RST;

	hsv_key_centroid_tracker_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.hue            (hue),
		.saturation     (saturation),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.frame_last     (frame_last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.key_hit        (key_hit),
		.frame_done     (frame_done),
		.center_x       (center_x),
		.center_y       (center_y),
		.center_updated (center_updated)
	);

	hsv_key_centroid_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.hue            (hue),
		.saturation     (saturation),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.frame_last     (frame_last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.key_hit        (key_hit),
		.frame_done     (frame_done),
		.center_x       (center_x),
		.center_y       (center_y),
		.center_updated (center_updated),
		.mismatches     (mismatches),
		.outstanding    (outstanding)
	);

	always #2 clk = ~clk;

	// receiver: random stall, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic apb_write(input logic [1:0] idx, input logic [APB_DW-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(
		input logic [HUE_W-1:0]   lo,
		input logic [HUE_W-1:0]   hi,
		input logic [SAT_W-1:0]   thr,
		input logic [ALPHA_W-1:0] a
	);
		apb_write(REG_HUE_LOWER, APB_DW'(lo));
		apb_write(REG_HUE_UPPER, APB_DW'(hi));
		apb_write(REG_SAT_THR, APB_DW'(thr));
		apb_write(REG_ALPHA, APB_DW'(a));
		cur_lo = lo;
		cur_hi = hi;
		cur_thr = thr;
		settings_used++;
	endtask

	task automatic send_pixel(
		input logic [HUE_W-1:0]   h,
		input logic [SAT_W-1:0]   s,
		input logic [COORD_W-1:0] px,
		input logic [COORD_W-1:0] py,
		input logic               last
	);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		hue <= h;
		saturation <= s;
		pos_x <= px;
		pos_y <= py;
		frame_last <= last;
		do @(posedge clk); while (in_stall);
		pixels_sent++;
		if (last)
			frames_sent++;
	endtask

	// stop offering words until every result is out, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_frame(input int len, input logic broken);
		logic [HUE_W-1:0] h;
		logic [SAT_W-1:0] s;
		logic             last;
		for (int i = 0; i < len; i++) begin
			h = HUE_W'($urandom_range(0, 179));
			// bias towards the key window so frames usually have hits
			if ($urandom_range(1) == 1 && cur_lo <= cur_hi && cur_lo <= 179)
				h = HUE_W'($urandom_range(cur_lo, (cur_hi > 179) ? 179 : cur_hi));
			if (cur_thr < 255 && $urandom_range(9) < 6)
				s = SAT_W'($urandom_range(cur_thr + 1, 255));
			else
				s = SAT_W'($urandom_range(0, 255));
			last = broken ? ($urandom_range(3) == 0) : (i == len - 1);
			send_pixel(h, s, COORD_W'($urandom_range(0, 1023)),
				COORD_W'($urandom_range(0, 1023)), last);
		end
	endtask

	function automatic logic [HUE_W-1:0] pick_bound();
		case ($urandom_range(5))
			0:       return '0;
			1:       return HUE_W'(180);
			2:       return '1;
			default: return HUE_W'($urandom_range(0, 180));
		endcase
	endfunction

	function automatic logic [SAT_W-1:0] pick_thr();
		case ($urandom_range(4))
			0:       return '0;
			1:       return '1;
			default: return SAT_W'($urandom_range(0, 200));
		endcase
	endfunction

	function automatic logic [ALPHA_W-1:0] pick_alpha();
		case ($urandom_range(5))
			0:       return '0;
			1:       return ALPHA_W'(ALPHA_ONE);
			2:       return '1;
			default: return ALPHA_W'($urandom_range(1, ALPHA_ONE));
		endcase
	endfunction

	initial begin
		int n;
		int len;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window wraps; alpha of zero keeps the centre at the origin
		send_pixel(175, 121, 100, 200, 1'b0);
		send_pixel(170, 121, 300, 400, 1'b1);
		drain();

		// plain window, bounds inclusive, saturation strictly above, alpha of one
		set_config(20, 40, 100, ALPHA_W'(ALPHA_ONE));
		send_pixel(20, 101, 0, 1023, 1'b0);
		send_pixel(40, 255, 1023, 0, 1'b0);
		send_pixel(19, 255, 7, 7, 1'b0);
		send_pixel(41, 255, 7, 7, 1'b0);
		send_pixel(30, 100, 7, 7, 1'b0);
		send_pixel(179, 0, 512, 511, 1'b1);
		// empty frame, then a word between frames showing the held centre
		send_pixel(0, 0, 1, 1, 1'b0);
		send_pixel(100, 255, 2, 2, 1'b1);
		send_pixel(30, 0, 3, 3, 1'b0);
		drain();

		// wrapped window with a lower bound past the hue range, alpha above one
		set_config(200, 10, 0, '1);
		send_pixel(0, 1, 10, 20, 1'b0);
		send_pixel(10, 255, 30, 40, 1'b0);
		send_pixel(11, 255, 50, 60, 1'b0);
		send_pixel(179, 255, 70, 80, 1'b0);
		send_pixel(5, 1, 1023, 1023, 1'b1);
		drain();

		// equal bounds take every hue, but nothing beats a full threshold
		set_config(90, 90, '1, 128);
		send_pixel(90, 255, 500, 500, 1'b0);
		send_pixel(0, 255, 600, 600, 1'b1);
		drain();

		set_config(0, 180, 254, 1);
		send_pixel(0, 255, 1, 2, 1'b0);
		send_pixel(179, 255, 1022, 1021, 1'b1);
		send_pixel(50, 0, 0, 0, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			set_config(pick_bound(), pick_bound(), pick_thr(), pick_alpha());
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			// long receiver hold-off while the sender keeps pushing
			if (p % 4 == 0)
				hold_reqs++;
			n = 0;
			while (n < PHASE_ITEMS) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
				send_frame(len, $urandom_range(9) == 0);
				n += len;
			end
		end
		drain();

		$display("covered %0d pixels in %0d frame ends over %0d register settings",
			pixels_sent, frames_sent, settings_used);
		$display("idling: none, sender 80%%, receiver 80%%, both 37%%, with long output hold-offs");
		if (mismatches == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#4000000;
		$display("Verification failed");
		$finish;
	end

endmodule
